// ===== src/c2f_pkg.sv =====
package c2f_pkg;

	// table size and stream widths
	localparam int C2F_MAX_WAYPOINTS = 256;
	localparam int C2F_S_TDATA_W     = 136;
	localparam int C2F_M_TDATA_W     = 72;
	localparam int C2F_CFG_DATA_W    = 27;

	// fixed point constants (q3.13 angles, q16.10 distances)
	localparam int          C2F_PI           = 25736;
	localparam int          C2F_QUARTER_PI   = 6434;
	localparam int          C2F_CORDIC_STEPS = 14;
	localparam logic [55:0] C2F_FAR_SQ       = 56'd10485760000000000;

	// root search unit widths
	localparam int C2F_N_W    = 110;
	localparam int C2F_B_W    = 56;
	localparam int C2F_T_W    = 30;
	localparam int C2F_Q_W    = 86;
	localparam int C2F_CAND_W = 118;

	// register indexes and item kinds
	localparam logic [1:0] CFG_COUNT    = 2'd0;
	localparam logic [1:0] CFG_CENTER_X = 2'd1;
	localparam logic [1:0] CFG_CENTER_Y = 2'd2;
	localparam logic       MODE_LOAD    = 1'b0;
	localparam logic       MODE_QUERY   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCAN_MX,
		ST_SCAN_MY,
		ST_BEST_RD,
		ST_BEST_LD,
		ST_CORDIC,
		ST_PICK,
		ST_PREV_LD,
		ST_NEXT_LD,
		ST_MUL,
		ST_DECIDE,
		ST_SQ,
		ST_ROOT_GO,
		ST_ROOT,
		ST_SUM_INIT,
		ST_SUM_FIRST,
		ST_SUM_MX,
		ST_SUM_M0,
		ST_SUM_M1,
		ST_OUT
	} c2f_state_t;

	typedef enum logic [1:0] {
		RP_DIST,
		RP_PROJ,
		RP_SEG
	} c2f_root_use_t;

	typedef struct packed {
		logic busy;
		logic done;
	} c2f_root_stat_t;

	// arctangent of 2^-i in q3.13
	function automatic logic [12:0] atan_step(input logic [3:0] i);
		logic [12:0] r;
		unique case (i)
			4'd0:    r = 13'd6434;
			4'd1:    r = 13'd3798;
			4'd2:    r = 13'd2007;
			4'd3:    r = 13'd1019;
			4'd4:    r = 13'd511;
			4'd5:    r = 13'd256;
			4'd6:    r = 13'd128;
			4'd7:    r = 13'd64;
			4'd8:    r = 13'd32;
			4'd9:    r = 13'd16;
			4'd10:   r = 13'd8;
			4'd11:   r = 13'd4;
			4'd12:   r = 13'd2;
			4'd13:   r = 13'd1;
			default: r = 13'd0;
		endcase
		return r;
	endfunction

	// difference of two coordinates, one bit wider
	function automatic logic signed [27:0] sub27(input logic signed [26:0] a,
		input logic signed [26:0] b);
		return $signed({a[26], a}) - $signed({b[26], b});
	endfunction

	function automatic logic [57:0] mag58(input logic signed [57:0] v);
		return v[57] ? 58'(-v) : 58'(v);
	endfunction

endpackage

// ===== src/c2f_root.sv =====
module c2f_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [c2f_pkg::C2F_N_W-1:0]   n,
	input  logic [c2f_pkg::C2F_B_W-1:0]   b,
	output c2f_pkg::c2f_root_stat_t       stat,
	output logic [c2f_pkg::C2F_T_W-1:0]   t
);
	import c2f_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic                  ph_q;
	logic [4:0]            bit_q;
	logic [C2F_N_W-1:0]    n_q;
	logic [C2F_B_W-1:0]    b_q;
	logic [C2F_N_W-1:0]    p_q;
	logic [C2F_Q_W-1:0]    q_q;
	logic [C2F_T_W-1:0]    t_q;
	logic [C2F_CAND_W-1:0] cand_q;
	logic [C2F_CAND_W-1:0] cand_c;

	// (t + 2^bit)^2 * b from running t^2*b and t*b
	assign cand_c = C2F_CAND_W'(p_q)
		+ (C2F_CAND_W'(q_q) << (bit_q + 5'd1))
		+ (C2F_CAND_W'(b_q) << {bit_q, 1'b0});

	// control: a candidate phase then a compare phase per result bit, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				bit_q  <= 5'(C2F_T_W - 1);
			end else if (busy_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					if (bit_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
			end
		end
	end

	// datapath: keep the candidate bit when its square still fits
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= n;
			b_q <= b;
			p_q <= '0;
			q_q <= '0;
			t_q <= '0;
		end else if (busy_q) begin
			if (!ph_q) begin
				cand_q <= cand_c;
			end else if (cand_q <= C2F_CAND_W'(n_q)) begin
				p_q <= cand_q[C2F_N_W-1:0];
				q_q <= q_q + (C2F_Q_W'(b_q) << bit_q);
				t_q <= t_q | (C2F_T_W'(1) << bit_q);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign t         = t_q;

endmodule

// ===== src/cartesian_to_frenet_converter_top.sv =====
// Cartesian to Frenet converter. A load transfer (tuser 0) writes one waypoint into the
// table and gives no result. A query transfer (tuser 1) finds the nearest of the first
// waypoint_count waypoints, advances to the following one when the heading differs from
// the bearing by more than pi/4, projects the position onto the segment that ends there
// and returns s, d, the chosen index and a zero-length-segment flag. The input is not
// ready while a query runs. Query time grows with the waypoint count and with prev, the
// index of the segment start: it is set by the shared root search unit (30 result bits),
// which gives every segment length, |d| and the projection, and by the single table read
// port scanned once per waypoint.
module cartesian_to_frenet_converter_top #(
	parameter int MAX_WAYPOINTS = c2f_pkg::C2F_MAX_WAYPOINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// wp_index, wp_x, wp_y, query_x, query_y, heading, zero fill
	input  logic [c2f_pkg::C2F_S_TDATA_W-1:0]   s_tdata,
	// mode
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// frenet_s, frenet_d, next_waypoint, zero fill
	output logic [c2f_pkg::C2F_M_TDATA_W-1:0]   m_tdata,
	// degenerate_segment
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [c2f_pkg::C2F_CFG_DATA_W-1:0]  cfg_data
);
	import c2f_pkg::*;

	localparam int AW   = $clog2(MAX_WAYPOINTS);
	localparam int CNTW = $clog2(MAX_WAYPOINTS + 1);

	// input fields
	logic [7:0]         in_wp_index;
	logic signed [26:0] in_wp_x, in_wp_y, in_qx, in_qy;
	logic signed [16:0] in_heading;
	assign in_wp_index = s_tdata[7:0];
	assign in_wp_x     = s_tdata[34:8];
	assign in_wp_y     = s_tdata[61:35];
	assign in_qx       = s_tdata[88:62];
	assign in_qy       = s_tdata[115:89];
	assign in_heading  = s_tdata[132:116];

	c2f_state_t state_q, state_d;

	logic [8:0]         count_q;
	logic signed [26:0] center_x_q, center_y_q;

	logic signed [26:0] qx_q, qy_q;
	logic signed [16:0] th_q;
	logic [CNTW-1:0]    cnt_q, cnt_clamp, cnt_m1;
	logic [AW-1:0]      last_idx;
	logic [AW-1:0]      i_q, best_q, next_q, prev_q, j_q;
	logic [AW-1:0]      addr_q, addr_c, pick_next, pick_prev;
	logic [55:0]        bestd2_q;
	logic signed [57:0] acc_q;
	logic signed [26:0] wpx_q, wpy_q;
	logic signed [27:0] nx_q, ny_q, px_q, py_q, cx_q, cy_q, ex_q, ey_q;
	logic signed [57:0] nn_q, dot_q, k_q, cm_q, sq_q, e2_q, c2_q;
	logic [3:0]         step_q;
	logic signed [30:0] cor_x_q, cor_y_q;
	logic signed [17:0] cor_z_q;
	logic               degen_q, neg_q;
	logic [29:0]        dmag_q, plen_q;
	logic [39:0]        s_acc_q;
	logic [C2F_N_W-1:0] root_n_q;
	logic [C2F_B_W-1:0] root_b_q;
	c2f_root_use_t      rp_q;
	logic               root_start;
	c2f_root_stat_t     root_stat;
	logic [C2F_T_W-1:0] root_t;

	logic               m_tvalid_q, out_deg_q;
	logic [31:0]        out_s_q;
	logic [28:0]        out_d_q;
	logic [7:0]         out_next_q;

	// waypoint table, one read port with registered data
	logic signed [26:0] mem_x [MAX_WAYPOINTS];
	logic signed [26:0] mem_y [MAX_WAYPOINTS];
	logic signed [26:0] rd_x_q, rd_y_q;
	logic [31:0]        wr_idx32;
	logic [AW-1:0]      wr_addr;
	logic               load_en;

	assign wr_idx32 = 32'(in_wp_index);
	assign wr_addr  = wr_idx32[AW-1:0];
	assign load_en  = s_tvalid && s_tready && (s_tuser[0] == MODE_LOAD)
		&& (wr_idx32 < 32'(MAX_WAYPOINTS));

	always_ff @(posedge clk) begin
		if (load_en) begin
			mem_x[wr_addr] <= in_wp_x;
			mem_y[wr_addr] <= in_wp_y;
		end
		rd_x_q <= mem_x[addr_c];
		rd_y_q <= mem_y[addr_c];
	end

	// count limits
	always_comb begin
		if (count_q == '0)
			cnt_clamp = CNTW'(1);
		else if (32'(count_q) > 32'(MAX_WAYPOINTS))
			cnt_clamp = CNTW'(MAX_WAYPOINTS);
		else
			cnt_clamp = CNTW'(count_q);
	end
	assign cnt_m1   = cnt_q - CNTW'(1);
	assign last_idx = cnt_m1[AW-1:0];

	// differences against the waypoint just read
	logic signed [27:0] rdx_c, rdy_c, sgx_c, sgy_c;
	assign rdx_c = sub27(rd_x_q, qx_q);
	assign rdy_c = sub27(rd_y_q, qy_q);
	assign sgx_c = sub27(rd_x_q, wpx_q);
	assign sgy_c = sub27(rd_y_q, wpy_q);

	// shared multiplier
	logic signed [28:0] ma, mb;
	logic signed [57:0] prod;
	logic [57:0]        sq_a;
	assign sq_a = mag58((rp_q == RP_PROJ) ? dot_q : k_q);
	assign prod = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SCAN_MX: begin ma = {rdx_c[27], rdx_c}; mb = ma; end
			ST_SCAN_MY: begin ma = {rdy_c[27], rdy_c}; mb = ma; end
			ST_SUM_M0:  begin ma = {nx_q[27], nx_q};   mb = ma; end
			ST_SUM_M1:  begin ma = {ny_q[27], ny_q};   mb = ma; end
			ST_MUL: begin
				case (step_q)
					4'd0:  begin ma = {nx_q[27], nx_q}; mb = {nx_q[27], nx_q}; end
					4'd1:  begin ma = {ny_q[27], ny_q}; mb = {ny_q[27], ny_q}; end
					4'd2:  begin ma = {px_q[27], px_q}; mb = {nx_q[27], nx_q}; end
					4'd3:  begin ma = {py_q[27], py_q}; mb = {ny_q[27], ny_q}; end
					4'd4:  begin ma = {nx_q[27], nx_q}; mb = {py_q[27], py_q}; end
					4'd5:  begin ma = {ny_q[27], ny_q}; mb = {px_q[27], px_q}; end
					4'd6:  begin ma = {nx_q[27], nx_q}; mb = {cy_q[27], cy_q}; end
					4'd7:  begin ma = {ny_q[27], ny_q}; mb = {cx_q[27], cx_q}; end
					4'd8:  begin ma = {px_q[27], px_q}; mb = {px_q[27], px_q}; end
					4'd9:  begin ma = {py_q[27], py_q}; mb = {py_q[27], py_q}; end
					4'd10: begin ma = {ex_q[27], ex_q}; mb = {ex_q[27], ex_q}; end
					4'd11: begin ma = {ey_q[27], ey_q}; mb = {ey_q[27], ey_q}; end
					4'd12: begin ma = {cx_q[27], cx_q}; mb = {cx_q[27], cx_q}; end
					default: begin ma = {cy_q[27], cy_q}; mb = {cy_q[27], cy_q}; end
				endcase
			end
			ST_SQ: begin
				case (step_q)
					4'd0: begin ma = {1'b0, sq_a[27:0]}; mb = ma; end
					4'd1: begin ma = {2'b0, sq_a[54:28]}; mb = {1'b0, sq_a[27:0]}; end
					default: begin ma = {2'b0, sq_a[54:28]}; mb = ma; end
				endcase
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// nearest search compare
	logic [55:0] d2_c;
	assign d2_c = 56'(acc_q + prod);

	// bearing clamp and the following waypoint choice
	logic signed [17:0] zc;
	logic signed [18:0] diff_c;
	logic [18:0]        adiff_c;
	always_comb begin
		if (cor_z_q > 18'sd25736)
			zc = 18'sd25736;
		else if (cor_z_q < -18'sd25736)
			zc = -18'sd25736;
		else
			zc = cor_z_q;
		diff_c  = {{2{th_q[16]}}, th_q} - {zc[17], zc};
		adiff_c = diff_c[18] ? 19'(-diff_c) : 19'(diff_c);
		if (adiff_c > 19'(C2F_QUARTER_PI))
			pick_next = (best_q == last_idx) ? '0 : best_q + AW'(1);
		else
			pick_next = best_q;
		pick_prev = (pick_next == '0) ? last_idx : pick_next - AW'(1);
	end

	// sign of d for a proper segment
	logic signed [59:0] tk_c;
	logic               k_pos, t_pos, degen_c;
	assign tk_c    = 60'(k_q) - (60'(cm_q) <<< 1);
	assign k_pos   = !k_q[57] && (k_q != '0);
	assign t_pos   = !tk_c[59] && (tk_c != '0);
	assign degen_c = (nn_q == '0);

	logic [30:0]        cxs, cys;
	logic signed [27:0] bx_c, by_c;
	assign bx_c = rdx_c;
	assign by_c = rdy_c;
	assign cxs  = cor_x_q >>> step_q;
	assign cys  = cor_y_q >>> step_q;

	// sequencer
	always_comb begin
		state_d    = state_q;
		addr_c     = addr_q;
		root_start = 1'b0;
		s_tready   = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (s_tuser[0] == MODE_QUERY)) begin
					addr_c  = '0;
					state_d = ST_SCAN_MX;
				end
			end
			ST_SCAN_MX: state_d = ST_SCAN_MY;
			ST_SCAN_MY: begin
				if (i_q == last_idx) begin
					state_d = ST_BEST_RD;
				end else begin
					addr_c  = i_q + AW'(1);
					state_d = ST_SCAN_MX;
				end
			end
			ST_BEST_RD: begin
				addr_c  = best_q;
				state_d = ST_BEST_LD;
			end
			ST_BEST_LD: state_d = (bx_c == '0 && by_c == '0) ? ST_PICK : ST_CORDIC;
			ST_CORDIC: begin
				if (step_q == 4'(C2F_CORDIC_STEPS - 1))
					state_d = ST_PICK;
			end
			ST_PICK: begin
				addr_c  = pick_prev;
				state_d = ST_PREV_LD;
			end
			ST_PREV_LD: begin
				addr_c  = next_q;
				state_d = ST_NEXT_LD;
			end
			ST_NEXT_LD: state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == 4'd13)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = degen_c ? ST_ROOT_GO : ST_SQ;
			ST_SQ: begin
				if (step_q == 4'd2)
					state_d = ST_ROOT_GO;
			end
			ST_ROOT_GO: begin
				root_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_stat.done) begin
					unique case (rp_q)
						RP_DIST: state_d = degen_q ? ST_SUM_INIT : ST_SQ;
						RP_PROJ: state_d = ST_SUM_INIT;
						RP_SEG: begin
							if (j_q == prev_q) begin
								state_d = ST_OUT;
							end else begin
								addr_c  = j_q + AW'(1);
								state_d = ST_SUM_MX;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SUM_INIT: begin
				if (prev_q == '0) begin
					state_d = ST_OUT;
				end else begin
					addr_c  = '0;
					state_d = ST_SUM_FIRST;
				end
			end
			ST_SUM_FIRST: begin
				addr_c  = AW'(1);
				state_d = ST_SUM_MX;
			end
			ST_SUM_MX: state_d = ST_SUM_M0;
			ST_SUM_M0: state_d = ST_SUM_M1;
			ST_SUM_M1: state_d = ST_ROOT_GO;
			ST_OUT: begin
				if (!m_tvalid_q || m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			count_q    <= 9'd1;
			center_x_q <= 27'sd1024000;
			center_y_q <= 27'sd2048000;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_COUNT:    count_q    <= cfg_data[8:0];
					CFG_CENTER_X: center_x_q <= cfg_data;
					CFG_CENTER_Y: center_y_q <= cfg_data;
					default:      count_q    <= count_q;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_q <= addr_c;
		case (state_q)
			ST_IDLE: begin
				qx_q     <= in_qx;
				qy_q     <= in_qy;
				th_q     <= in_heading;
				cnt_q    <= cnt_clamp;
				i_q      <= '0;
				best_q   <= '0;
				bestd2_q <= C2F_FAR_SQ;
			end
			ST_SCAN_MX: acc_q <= prod;
			ST_SCAN_MY: begin
				if (d2_c < bestd2_q) begin
					bestd2_q <= d2_c;
					best_q   <= i_q;
				end
				i_q <= i_q + AW'(1);
			end
			ST_BEST_LD: begin
				step_q <= '0;
				if (bx_c == '0 && by_c == '0) begin
					cor_z_q <= '0;
				end else if (bx_c[27]) begin
					cor_x_q <= -{{3{bx_c[27]}}, bx_c};
					cor_y_q <= -{{3{by_c[27]}}, by_c};
					cor_z_q <= by_c[27] ? -18'sd25736 : 18'sd25736;
				end else begin
					cor_x_q <= {{3{bx_c[27]}}, bx_c};
					cor_y_q <= {{3{by_c[27]}}, by_c};
					cor_z_q <= '0;
				end
			end
			// one rotation per cycle toward the x axis
			ST_CORDIC: begin
				step_q <= step_q + 4'd1;
				if (!cor_y_q[30] && cor_y_q != '0) begin
					cor_x_q <= cor_x_q + $signed(cys);
					cor_y_q <= cor_y_q - $signed(cxs);
					cor_z_q <= cor_z_q + $signed({5'b0, atan_step(step_q)});
				end else begin
					cor_x_q <= cor_x_q - $signed(cys);
					cor_y_q <= cor_y_q + $signed(cxs);
					cor_z_q <= cor_z_q - $signed({5'b0, atan_step(step_q)});
				end
			end
			ST_PICK: begin
				next_q <= pick_next;
				prev_q <= pick_prev;
			end
			ST_PREV_LD: begin
				wpx_q <= rd_x_q;
				wpy_q <= rd_y_q;
			end
			ST_NEXT_LD: begin
				nx_q   <= sgx_c;
				ny_q   <= sgy_c;
				px_q   <= sub27(qx_q, wpx_q);
				py_q   <= sub27(qy_q, wpy_q);
				cx_q   <= sub27(center_x_q, wpx_q);
				cy_q   <= sub27(center_y_q, wpy_q);
				ex_q   <= sub27(center_x_q, qx_q);
				ey_q   <= sub27(center_y_q, qy_q);
				step_q <= '0;
			end
			// products for segment length, dot, cross and the center tests
			ST_MUL: begin
				step_q <= step_q + 4'd1;
				case (step_q)
					4'd0:  nn_q <= prod;
					4'd1:  nn_q <= nn_q + prod;
					4'd2:  dot_q <= prod;
					4'd3:  dot_q <= dot_q + prod;
					4'd4:  k_q <= prod;
					4'd5:  k_q <= k_q - prod;
					4'd6:  cm_q <= prod;
					4'd7:  cm_q <= cm_q - prod;
					4'd8:  sq_q <= prod;
					4'd9:  sq_q <= sq_q + prod;
					4'd10: e2_q <= prod;
					4'd11: e2_q <= e2_q + prod;
					4'd12: c2_q <= prod;
					default: c2_q <= c2_q + prod;
				endcase
			end
			ST_DECIDE: begin
				degen_q <= degen_c;
				rp_q    <= RP_DIST;
				step_q  <= '0;
				if (degen_c) begin
					neg_q    <= (e2_q <= c2_q);
					plen_q   <= '0;
					root_n_q <= C2F_N_W'(sq_q[55:0]);
					root_b_q <= C2F_B_W'(1);
				end else begin
					neg_q    <= (k_q == '0) || (tk_c == '0) || (k_pos != t_pos);
					root_b_q <= nn_q[55:0];
				end
			end
			// square of |cross| or |dot| in three partial products
			ST_SQ: begin
				step_q <= step_q + 4'd1;
				case (step_q)
					4'd0: root_n_q <= C2F_N_W'(prod[56:0]);
					4'd1: root_n_q <= root_n_q + (C2F_N_W'(prod[56:0]) << 29);
					default: root_n_q <= root_n_q + (C2F_N_W'(prod[56:0]) << 56);
				endcase
			end
			ST_ROOT: begin
				if (root_stat.done) begin
					case (rp_q)
						RP_DIST: begin
							dmag_q <= root_t;
							rp_q   <= RP_PROJ;
							step_q <= '0;
						end
						RP_PROJ: plen_q <= root_t;
						default: begin
							s_acc_q <= s_acc_q + 40'(root_t);
							j_q     <= j_q + AW'(1);
						end
					endcase
				end
			end
			ST_SUM_INIT: s_acc_q <= 40'(plen_q);
			ST_SUM_FIRST: begin
				wpx_q <= rd_x_q;
				wpy_q <= rd_y_q;
				j_q   <= AW'(1);
			end
			ST_SUM_MX: begin
				nx_q  <= sgx_c;
				ny_q  <= sgy_c;
				wpx_q <= rd_x_q;
				wpy_q <= rd_y_q;
			end
			ST_SUM_M0: acc_q <= prod;
			ST_SUM_M1: begin
				root_n_q <= C2F_N_W'(d2_c);
				root_b_q <= C2F_B_W'(1);
				rp_q     <= RP_SEG;
			end
			default: acc_q <= acc_q;
		endcase
	end

	// result register
	logic [29:0] dsig_c;
	logic [31:0] next32;
	assign dsig_c = neg_q ? (30'd0 - dmag_q) : dmag_q;
	assign next32 = 32'(next_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			out_s_q    <= (s_acc_q[39:32] != '0) ? 32'hFFFF_FFFF : s_acc_q[31:0];
			out_d_q    <= dsig_c[28:0];
			out_next_q <= next32[7:0];
			out_deg_q  <= degen_q;
		end
	end

	c2f_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.n      (root_n_q),
		.b      (root_b_q),
		.stat   (root_stat),
		.t      (root_t)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'b0, out_next_q, out_d_q, out_s_q};
	assign m_tuser   = out_deg_q;

	// root unit is never restarted while busy
	a_root_idle: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_stat.busy)
		else $error("root search started while busy");

	// a root result only arrives while the sequencer waits for it
	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.done |-> (state_q == ST_ROOT))
		else $error("root result arrived outside wait state");

	// chosen segment lies within the active table
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (next_q <= last_idx && prev_q <= last_idx))
		else $error("segment index beyond waypoint count");

	// zero-length segment has no projection
	a_degen_plen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && degen_q) |-> (plen_q == '0))
		else $error("projection nonzero on zero-length segment");

endmodule
